/* hdl/frustum_plane_extract_and_cull_macros.svh */
// ----------------------------------------------------------------------------
// frustum culling assertion macros
// shared property forms used by the culling block
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_EXTRACT_AND_CULL_MACROS_SVH
`define FRUSTUM_PLANE_EXTRACT_AND_CULL_MACROS_SVH

// same-cycle implication
`define FPEC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FPEC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/fpec_pkg.sv */
// ----------------------------------------------------------------------------
// fpec_pkg
// shared constants, codes and helpers of the frustum culling block
// ----------------------------------------------------------------------------
package fpec_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PLANE_COUNT = 6;
   localparam int WORD_W      = 32;
   localparam int DIV_W       = 31 + FRAC_BITS;
   localparam int CNT_W       = $clog2(DIV_W + 1);
   localparam int SQRT_STEPS  = 32;
   localparam int ACC_W       = 68;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_EXTRACT = 2'd1,
      FUNC_TEST    = 2'd2
   } func_type;

   typedef enum logic {
      KIND_BOX     = 1'b0,
      KIND_EXTRACT = 1'b1
   } kind_type;

   // matrix row combined with row 3 for each plane
   function automatic logic [1:0] row_sel(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0, 3'd1: r = 2'd0;
         3'd2, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   // planes that subtract the selected row
   function automatic logic row_neg(input logic [2:0] p);
      logic n;
      unique case (p)
         3'd0, 3'd3, 3'd4: n = 1'b1;
         default:          n = 1'b0;
      endcase
      return n;
   endfunction

endpackage

/* hdl/fpec_channels.sv */
// ----------------------------------------------------------------------------
// fpec channels
// request and response channel interfaces of the frustum culling block
// ----------------------------------------------------------------------------
interface fpec_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic [3:0]                          mat_index;
   logic signed [fpec_pkg::WORD_W-1:0]  mat_value;
   logic signed [fpec_pkg::WORD_W-1:0]  box_x_min;
   logic signed [fpec_pkg::WORD_W-1:0]  box_x_max;
   logic signed [fpec_pkg::WORD_W-1:0]  box_y_min;
   logic signed [fpec_pkg::WORD_W-1:0]  box_y_max;
   logic signed [fpec_pkg::WORD_W-1:0]  box_z_min;
   logic signed [fpec_pkg::WORD_W-1:0]  box_z_max;

   modport source (output valid, func, mat_index, mat_value, box_x_min, box_x_max,
                   box_y_min, box_y_max, box_z_min, box_z_max, input ready);
   modport sink   (input valid, func, mat_index, mat_value, box_x_min, box_x_max,
                   box_y_min, box_y_max, box_z_min, box_z_max, output ready);
endinterface

interface fpec_rsp_if;
   logic valid;
   logic ready;
   logic kind;
   logic visible;
   logic degenerate;

   modport source (output valid, kind, visible, degenerate, input ready);
   modport sink   (input valid, kind, visible, degenerate, output ready);
endinterface

/* hdl/frustum_plane_extract_and_cull.sv */
// ----------------------------------------------------------------------------
// frustum_plane_extract_and_cull
// clip plane extraction from a stored matrix and bounding-sphere box culling
// ----------------------------------------------------------------------------
// matrix write: no response
// box test: squares, 32-step root, 24 streamed plane reads; straight to the response with no planes
// extraction: per plane, the alignment shifts and the bit-serial root, then the
//   47-step divider run once per plane component
// one request in flight; the next is taken the cycle after the response is loaded
// synchronous reset clears control, plane valid and skip flags
`include "frustum_plane_extract_and_cull_macros.svh"

module frustum_plane_extract_and_cull (
   input  logic        clock,
   input  logic        reset,
   fpec_req_if.sink    req_bus,
   fpec_rsp_if.source  rsp_bus
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_LOAD   = 14'b00000000000010,
      ST_CAPT   = 14'b00000000000100,
      ST_ALIGN  = 14'b00000000001000,
      ST_SQUARE = 14'b00000000010000,
      ST_CHECK  = 14'b00000000100000,
      ST_SQRT   = 14'b00000001000000,
      ST_POST   = 14'b00000010000000,
      ST_DSTART = 14'b00000100000000,
      ST_DIV    = 14'b00001000000000,
      ST_WRITE  = 14'b00010000000000,
      ST_BOXRUN = 14'b00100000000000,
      ST_DRAIN  = 14'b01000000000000,
      ST_RESP   = 14'b10000000000000
   } state_type;

   localparam int DW = fpec_pkg::DIV_W;
   localparam int CW = fpec_pkg::CNT_W;
   localparam int AW = fpec_pkg::ACC_W;
   localparam int F  = fpec_pkg::FRAC_BITS;

   state_type state_ff, state_in;

   logic [31:0] mat_mem [16];
   logic [31:0] plane_mem [24];
   logic [31:0] mat_a_ff, mat_b_ff, plane_q_ff;

   logic        mode_box_ff;
   logic [2:0]  p_ff;
   logic [1:0]  k_ff;
   logic [32:0] mag_ff [4];
   logic        neg_ff [4];
   logic [5:0]  skip_ff;
   logic        deg_ff, planes_valid_ff, zero_ff;

   logic signed [32:0] c2_ff [3];
   logic [31:0]        h_ff [3];

   logic [63:0] sq_prod_ff, ssum_ff;
   logic [63:0] rad_ff;
   logic [33:0] srem_ff;
   logic [31:0] root_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] dnum_ff, dq_ff;
   logic [32:0]   drem_ff;
   logic [32:0]   radius_ff;

   logic [4:0]  idx_ff, tag1_ff, tag2_ff;
   logic        v1_ff, v2_ff, cull_ff;
   logic signed [64:0]   prod_ff;
   logic signed [AW-1:0] acc_ff;

   logic rsp_valid_ff, rsp_kind_ff, rsp_vis_ff, rsp_deg_ff;
   logic res_kind_ff, res_vis_ff, res_deg_ff;

   logic accept, slot_free, any_hi, need_left;
   logic [31:0] sq_op;
   logic [63:0] sq_prod_in;
   logic signed [32:0] raw_a, raw_b, raw;
   logic signed [32:0] lo_v [3], hi_v [3], diff_v [3];
   logic [32:0]  ad_v [3];
   logic [33:0]  hp_v [3];
   logic [35:0]  srem_next;
   logic [35:0]  strial;
   logic [33:0]  drem_next;
   logic [DW-1:0] qlim, qsat;
   logic [31:0]  wr_val;
   logic signed [32:0]   c2sel;
   logic signed [AW-1:0] rterm, acc_base, acc_sum;

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = rsp_kind_ff;
   assign rsp_bus.visible    = rsp_vis_ff;
   assign rsp_bus.degenerate = rsp_deg_ff;

   // plane component magnitude alignment
   always_comb begin
      any_hi    = 1'b0;
      need_left = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (mag_ff[i][32:31] != 2'b00) any_hi = 1'b1;
         if (mag_ff[i][32:30] != 3'b000) need_left = 1'b0;
      end
      if ((mag_ff[0] | mag_ff[1] | mag_ff[2] | mag_ff[3]) == 33'd0) need_left = 1'b0;
   end

   always_comb begin
      raw_a = {mat_a_ff[31], mat_a_ff};
      raw_b = {mat_b_ff[31], mat_b_ff};
      raw   = fpec_pkg::row_neg(p_ff) ? (raw_a - raw_b) : (raw_a + raw_b);
   end

   always_comb begin
      lo_v[0] = {req_bus.box_x_min[31], req_bus.box_x_min};
      hi_v[0] = {req_bus.box_x_max[31], req_bus.box_x_max};
      lo_v[1] = {req_bus.box_y_min[31], req_bus.box_y_min};
      hi_v[1] = {req_bus.box_y_max[31], req_bus.box_y_max};
      lo_v[2] = {req_bus.box_z_min[31], req_bus.box_z_min};
      hi_v[2] = {req_bus.box_z_max[31], req_bus.box_z_max};
      for (int a = 0; a < 3; a++) begin
         diff_v[a] = hi_v[a] - lo_v[a];
         ad_v[a]   = diff_v[a][32] ? 33'(-diff_v[a]) : 33'(diff_v[a]);
         hp_v[a]   = {1'b0, ad_v[a]} + 34'd1;
      end
   end

   always_comb begin
      unique case (k_ff)
         2'd0:    sq_op = mode_box_ff ? h_ff[0] : {1'b0, mag_ff[0][30:0]};
         2'd1:    sq_op = mode_box_ff ? h_ff[1] : {1'b0, mag_ff[1][30:0]};
         default: sq_op = mode_box_ff ? h_ff[2] : {1'b0, mag_ff[2][30:0]};
      endcase
      sq_prod_in = sq_op * sq_op;
   end

   assign srem_next = {srem_ff, rad_ff[63:62]};
   assign strial    = {2'b00, root_ff, 2'b01};
   assign drem_next = {drem_ff, dnum_ff[DW-1]};

   always_comb begin
      qlim   = neg_ff[k_ff] ? (DW'(1) << 31) : ((DW'(1) << 31) - DW'(1));
      qsat   = (dq_ff > qlim) ? qlim : dq_ff;
      wr_val = zero_ff ? 32'd0 : (neg_ff[k_ff] ? (32'd0 - qsat[31:0]) : qsat[31:0]);
   end

   always_comb begin
      unique case (tag1_ff[1:0])
         2'd0:    c2sel = c2_ff[0];
         2'd1:    c2sel = c2_ff[1];
         2'd2:    c2sel = c2_ff[2];
         default: c2sel = 33'sd1 <<< (F + 1);
      endcase
      rterm    = $signed({{(AW-33){1'b0}}, radius_ff}) <<< (F + 1);
      acc_base = (tag2_ff[1:0] == 2'd0) ? rterm : acc_ff;
      acc_sum  = acc_base + AW'(prod_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_bus.func)
                  fpec_pkg::FUNC_EXTRACT: state_in = ST_LOAD;
                  fpec_pkg::FUNC_TEST:    state_in = planes_valid_ff ? ST_SQUARE : ST_RESP;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:   state_in = ST_CAPT;
         ST_CAPT:   state_in = (k_ff == 2'd3) ? ST_ALIGN : ST_LOAD;
         ST_ALIGN:  state_in = (any_hi || need_left) ? ST_ALIGN : ST_SQUARE;
         ST_SQUARE: state_in = (k_ff == 2'd3) ? ST_CHECK : ST_SQUARE;
         ST_CHECK:  state_in = (!mode_box_ff && ssum_ff == 64'd0) ? ST_WRITE : ST_SQRT;
         ST_SQRT:   state_in = (cnt_ff == CW'(fpec_pkg::SQRT_STEPS - 1)) ? ST_POST : ST_SQRT;
         ST_POST:   state_in = mode_box_ff ? ST_BOXRUN : ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV:    state_in = (cnt_ff == CW'(DW - 1)) ? ST_WRITE : ST_DIV;
         ST_WRITE: begin
            if (k_ff == 2'd3)
               state_in = (p_ff == 3'(fpec_pkg::PLANE_COUNT - 1)) ? ST_RESP : ST_LOAD;
            else
               state_in = zero_ff ? ST_WRITE : ST_DSTART;
         end
         ST_BOXRUN: state_in = (idx_ff == 5'd23) ? ST_DRAIN : ST_BOXRUN;
         ST_DRAIN:  state_in = (!v1_ff && !v2_ff) ? ST_RESP : ST_DRAIN;
         ST_RESP:   state_in = slot_free ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept && req_bus.func == fpec_pkg::FUNC_WRITE)
         mat_mem[req_bus.mat_index] <= req_bus.mat_value;
      if (state_ff == ST_LOAD) begin
         mat_a_ff <= mat_mem[{k_ff, 2'd3}];
         mat_b_ff <= mat_mem[{k_ff, fpec_pkg::row_sel(p_ff)}];
      end
      if (state_ff == ST_WRITE)
         plane_mem[{p_ff, k_ff}] <= wr_val;
      if (state_ff == ST_BOXRUN)
         plane_q_ff <= plane_mem[idx_ff];
   end

   // datapath
   always_ff @(posedge clock) begin
      sq_prod_ff <= sq_prod_in;
      tag1_ff    <= idx_ff;
      tag2_ff    <= tag1_ff;
      prod_ff    <= $signed(plane_q_ff) * c2sel;
      unique case (state_ff)
         ST_IDLE: begin
            k_ff <= 2'd0;
            p_ff <= 3'd0;
            for (int a = 0; a < 3; a++) begin
               c2_ff[a] <= lo_v[a] + hi_v[a];
               h_ff[a]  <= hp_v[a][32:1];
            end
         end
         ST_CAPT: begin
            mag_ff[k_ff] <= raw[32] ? 33'(-raw) : 33'(raw);
            neg_ff[k_ff] <= raw[32];
            k_ff         <= k_ff + 2'd1;
         end
         ST_ALIGN: begin
            for (int i = 0; i < 4; i++) begin
               if (any_hi)         mag_ff[i] <= mag_ff[i] >> 1;
               else if (need_left) mag_ff[i] <= mag_ff[i] << 1;
            end
         end
         ST_SQUARE: begin
            ssum_ff <= (k_ff == 2'd0) ? 64'd0 : (ssum_ff + sq_prod_ff);
            k_ff    <= k_ff + 2'd1;
         end
         ST_CHECK: begin
            rad_ff  <= ssum_ff;
            srem_ff <= 34'd0;
            root_ff <= 32'd0;
            cnt_ff  <= '0;
            zero_ff <= !mode_box_ff && (ssum_ff == 64'd0);
            k_ff    <= 2'd0;
         end
         ST_SQRT: begin
            if (srem_next >= strial) begin
               srem_ff <= 34'(srem_next - strial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= srem_next[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            rad_ff <= rad_ff << 2;
            cnt_ff <= cnt_ff + CW'(1);
         end
         ST_POST: begin
            radius_ff <= {1'b0, root_ff} + {32'd0, (srem_ff != 34'd0)};
            idx_ff    <= 5'd0;
         end
         ST_DSTART: begin
            dnum_ff <= {mag_ff[k_ff][30:0], {F{1'b0}}};
            drem_ff <= 33'd0;
            dq_ff   <= '0;
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            if (drem_next >= {2'b00, root_ff}) begin
               drem_ff <= 33'(drem_next - {2'b00, root_ff});
               dq_ff   <= {dq_ff[DW-2:0], 1'b1};
            end else begin
               drem_ff <= drem_next[32:0];
               dq_ff   <= {dq_ff[DW-2:0], 1'b0};
            end
            dnum_ff <= dnum_ff << 1;
            cnt_ff  <= cnt_ff + CW'(1);
         end
         ST_WRITE: begin
            k_ff <= k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               p_ff    <= p_ff + 3'd1;
               zero_ff <= 1'b0;
            end
         end
         ST_BOXRUN: idx_ff <= idx_ff + 5'd1;
         default: ;
      endcase
      if (v2_ff) acc_ff <= acc_sum;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_box_ff     <= 1'b0;
         skip_ff         <= 6'd0;
         deg_ff          <= 1'b0;
         planes_valid_ff <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         cull_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         res_kind_ff     <= 1'b0;
         res_vis_ff      <= 1'b0;
         res_deg_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == ST_BOXRUN);
         v2_ff    <= v1_ff;
         if (accept) begin
            mode_box_ff <= (req_bus.func == fpec_pkg::FUNC_TEST);
            cull_ff     <= 1'b0;
            res_kind_ff <= fpec_pkg::KIND_BOX;
            res_vis_ff  <= 1'b1;
            res_deg_ff  <= 1'b0;
            if (req_bus.func == fpec_pkg::FUNC_EXTRACT) begin
               skip_ff <= 6'd0;
               deg_ff  <= 1'b0;
            end
         end
         if (state_ff == ST_CHECK && !mode_box_ff && ssum_ff == 64'd0) begin
            skip_ff[p_ff] <= 1'b1;
            deg_ff        <= 1'b1;
         end
         if (v2_ff && tag2_ff[1:0] == 2'd3 && !skip_ff[tag2_ff[4:2]] &&
             (acc_sum[AW-1] || acc_sum == '0))
            cull_ff <= 1'b1;
         if (state_ff == ST_WRITE && state_in == ST_RESP) begin
            planes_valid_ff <= 1'b1;
            res_kind_ff     <= fpec_pkg::KIND_EXTRACT;
            res_vis_ff      <= 1'b0;
            res_deg_ff      <= deg_ff;
         end
         if (state_ff == ST_DRAIN && state_in == ST_RESP)
            res_vis_ff <= !cull_ff;
         if (state_ff == ST_RESP && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff  <= res_kind_ff;
            rsp_vis_ff   <= res_vis_ff;
            rsp_deg_ff   <= res_deg_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `FPEC_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_ff))
   `FPEC_ASSERT_NEXT(a_resp_loaded, state_ff == ST_RESP && slot_free, rsp_bus.valid)
   `FPEC_ASSERT_NOW(a_extract_flags, rsp_bus.valid && rsp_bus.kind, !rsp_bus.visible && planes_valid_ff)
   `FPEC_ASSERT_NOW(a_box_flags, rsp_bus.valid && !rsp_bus.kind, !rsp_bus.degenerate)

endmodule

/* tb/sv/tb_frustum_plane_extract_and_cull.sv */
// ----------------------------------------------------------------------------
// tb_frustum_plane_extract_and_cull
// drives matrix writes, plane extractions, box tests and unused function codes into
// the culling block with random idling on both channels, predicts every response
// from its own copy of the matrix and planes, and compares field by field
// ----------------------------------------------------------------------------
module tb_frustum_plane_extract_and_cull;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         func;
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic signed [31:0] bx [6];
   } cull_req_type;

   typedef struct {
      logic kind;
      logic visible;
      logic degenerate;
   } cull_rsp_type;

   typedef struct {
      cull_req_type req;
      logic         chk;
      cull_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpec_req_if req_bus();
   fpec_rsp_if rsp_bus();

   frustum_plane_extract_and_cull u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0]  mat_copy [16];
   logic [31:0]  plane_copy [24];
   logic         planes_ok;
   logic [5:0]   skip_mask;
   cull_rsp_type expected_q [$];
   int           err_count = 0;
   int           n_box = 0, n_ext = 0, n_culled = 0, n_deg = 0;
   logic         calm = 1'b0;
   logic         send_done = 1'b0;

   function automatic logic [63:0] root_floor(input logic [63:0] s);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > s) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (s >= res + bit_v) begin
            s = s - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic derive_planes();
      logic        deg;
      logic [63:0] mag [4];
      logic        ng [4];
      logic [63:0] mx, s, t, q, lim;
      longint      a, b, v;
      int          p, k;
      logic [1:0]  rs;
      logic        rn;
      deg = 1'b0;
      skip_mask = 0;
      for (p = 0; p < 6; p++) begin
         rs = (p < 2) ? 2'd0 : (p < 4) ? 2'd1 : 2'd2;
         rn = (p == 0 || p == 3 || p == 4);
         mx = 0;
         for (k = 0; k < 4; k++) begin
            a = longint'($signed(mat_copy[4*k+3]));
            b = longint'($signed(mat_copy[4*k+rs]));
            v = rn ? a - b : a + b;
            ng[k] = v < 0;
            mag[k] = v < 0 ? -v : v;
            if (mag[k] > mx) mx = mag[k];
         end
         while (mx >= 64'h8000_0000) begin
            for (k = 0; k < 4; k++) mag[k] = mag[k] >> 1;
            mx = mx >> 1;
         end
         while (mx != 0 && mx < 64'h4000_0000) begin
            for (k = 0; k < 4; k++) mag[k] = mag[k] << 1;
            mx = mx << 1;
         end
         s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
         if (s == 0) begin
            for (k = 0; k < 4; k++) plane_copy[4*p+k] = 0;
            skip_mask[p] = 1'b1;
            deg = 1'b1;
         end else begin
            t = root_floor(s);
            for (k = 0; k < 4; k++) begin
               q = (mag[k] << fpec_pkg::FRAC_BITS) / t;
               lim = ng[k] ? 64'h8000_0000 : 64'h7FFF_FFFF;
               if (q > lim) q = lim;
               plane_copy[4*p+k] = ng[k] ? 32'(-q) : 32'(q);
            end
         end
      end
      planes_ok = 1'b1;
      return deg;
   endfunction

   function automatic logic box_survives(input cull_req_type r);
      longint      c2 [3];
      logic [63:0] s, h, rad;
      longint      lo, hi, dd, rterm, l;
      int          ax, p;
      s = 0;
      for (ax = 0; ax < 3; ax++) begin
         lo = longint'(r.bx[2*ax]);
         hi = longint'(r.bx[2*ax+1]);
         dd = hi - lo;
         if (dd < 0) dd = -dd;
         h = (64'(dd) + 1) >> 1;
         c2[ax] = lo + hi;
         s += h * h;
      end
      rad = root_floor(s);
      if (rad * rad < s) rad++;
      rterm = longint'(rad) * (longint'(1) << (fpec_pkg::FRAC_BITS + 1));
      for (p = 0; p < 6; p++) begin
         if (!skip_mask[p]) begin
            l = longint'($signed(plane_copy[4*p])) * c2[0]
              + longint'($signed(plane_copy[4*p+1])) * c2[1]
              + longint'($signed(plane_copy[4*p+2])) * c2[2]
              + longint'($signed(plane_copy[4*p+3]))
                * (longint'(1) << (fpec_pkg::FRAC_BITS + 1));
            if (l + rterm <= 0) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // updates the copy of the block state and, for extractions and box tests, queues the expected response
   task automatic predict_cull(input cull_req_type r, input logic chk,
                               input cull_rsp_type typed);
      cull_rsp_type e;
      e = '{kind: 1'b0, visible: 1'b0, degenerate: 1'b0};
      case (r.func)
         fpec_pkg::FUNC_WRITE: begin
            mat_copy[r.idx] = r.val;
            return;
         end
         fpec_pkg::FUNC_EXTRACT: begin
            e.kind = fpec_pkg::KIND_EXTRACT;
            e.degenerate = derive_planes();
            n_ext++;
            if (e.degenerate) n_deg++;
         end
         fpec_pkg::FUNC_TEST: begin
            e.kind = fpec_pkg::KIND_BOX;
            e.visible = !planes_ok || box_survives(r);
            n_box++;
            if (!e.visible) n_culled++;
         end
         default: return;
      endcase
      if (chk && e != typed) begin
         $error("typed expectation disagrees with predictor");
         err_count++;
      end
      expected_q.push_back(e);
   endtask

   task automatic drive_request(input cull_req_type r);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= r.func;
      req_bus.mat_index <= r.idx;
      req_bus.mat_value <= r.val;
      req_bus.box_x_min <= r.bx[0];
      req_bus.box_x_max <= r.bx[1];
      req_bus.box_y_min <= r.bx[2];
      req_bus.box_y_max <= r.bx[3];
      req_bus.box_z_min <= r.bx[4];
      req_bus.box_z_max <= r.bx[5];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   function automatic cull_req_type make_req(input logic [1:0] f, input logic [3:0] i,
                                             input logic [31:0] v);
      cull_req_type r;
      r.func = f;
      r.idx = i;
      r.val = v;
      foreach (r.bx[k]) r.bx[k] = 0;
      return r;
   endfunction

   function automatic logic [31:0] rand_word(input int scale);
      case (scale)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   function automatic cull_req_type rand_box();
      cull_req_type r;
      int sc;
      r = make_req(fpec_pkg::FUNC_TEST, 4'($urandom()), $urandom());
      sc = $urandom_range(0, 4);
      foreach (r.bx[k]) r.bx[k] = rand_word(sc == 0 ? 0 : 2);
      return r;
   endfunction

   task automatic run_row(input stim_row_type row);
      predict_cull(row.req, row.chk, row.rsp);
      drive_request(row.req);
   endtask

   // response side
   always @(posedge clock) begin
      cull_rsp_type a, e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a = '{kind: rsp_bus.kind, visible: rsp_bus.visible,
               degenerate: rsp_bus.degenerate};
         if (expected_q.size() == 0) begin
            $error("response with nothing expected");
            err_count++;
         end else begin
            e = expected_q.pop_front();
            if (a.kind !== e.kind) begin
               $error("kind: expected %0d actual %0d", e.kind, a.kind);
               err_count++;
            end
            if (a.visible !== e.visible) begin
               $error("visible: expected %0d actual %0d", e.visible, a.visible);
               err_count++;
            end
            if (a.degenerate !== e.degenerate) begin
               $error("degenerate: expected %0d actual %0d", e.degenerate, a.degenerate);
               err_count++;
            end
         end
      end
   end

   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (1) begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      #60_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      stim_row_type dir [$];
      stim_row_type row;
      cull_req_type r;
      cull_rsp_type none, vis, ext0, ext1;
      int i, k, n, cyc;
      logic [31:0] m [16];
      none = '{kind: fpec_pkg::KIND_BOX, visible: 1'b0, degenerate: 1'b0};
      vis  = '{kind: fpec_pkg::KIND_BOX, visible: 1'b1, degenerate: 1'b0};
      ext0 = '{kind: fpec_pkg::KIND_EXTRACT, visible: 1'b0, degenerate: 1'b0};
      ext1 = '{kind: fpec_pkg::KIND_EXTRACT, visible: 1'b0, degenerate: 1'b1};
      planes_ok = 1'b0;
      skip_mask = 0;
      foreach (plane_copy[k]) plane_copy[k] = 0;
      foreach (mat_copy[k]) mat_copy[k] = 0;
      req_bus.valid = 1'b0;
      req_bus.func = fpec_pkg::FUNC_WRITE;
      req_bus.mat_index = 0;
      req_bus.mat_value = 0;
      req_bus.box_x_min = 0;
      req_bus.box_x_max = 0;
      req_bus.box_y_min = 0;
      req_bus.box_y_max = 0;
      req_bus.box_z_min = 0;
      req_bus.box_z_max = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no planes yet: an extreme box and an all-zero box are visible
      r = make_req(fpec_pkg::FUNC_TEST, 0, 0);
      foreach (r.bx[k]) r.bx[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      dir.push_back('{req: r, chk: 1'b1, rsp: vis});
      r = make_req(fpec_pkg::FUNC_TEST, 0, 0);
      dir.push_back('{req: r, chk: 1'b1, rsp: vis});
      // unused func code, ignored
      r = make_req(FUNC_UNUSED, 4'hF, 32'hFFFF_FFFF);
      dir.push_back('{req: r, chk: 1'b0, rsp: none});
      // all-zero matrix: every plane degenerate
      for (i = 0; i < 16; i++)
         dir.push_back('{req: make_req(fpec_pkg::FUNC_WRITE, 4'(i), 0), chk: 1'b0,
                         rsp: none});
      dir.push_back('{req: make_req(fpec_pkg::FUNC_EXTRACT, 0, 0), chk: 1'b1, rsp: ext1});
      r = make_req(fpec_pkg::FUNC_TEST, 0, 0);
      dir.push_back('{req: r, chk: 1'b1, rsp: vis});
      foreach (dir[k]) run_row(dir[k]);
      dir.delete();

      // identity matrix, then extremes written into it
      for (i = 0; i < 16; i++) begin
         row = '{req: make_req(fpec_pkg::FUNC_WRITE, 4'(i),
                               (i % 5 == 0) ? 32'h0001_0000 : 0),
                 chk: 1'b0, rsp: none};
         run_row(row);
      end
      run_row('{req: make_req(fpec_pkg::FUNC_EXTRACT, 0, 0), chk: 1'b1, rsp: ext0});
      r = make_req(fpec_pkg::FUNC_TEST, 0, 0);
      r.bx[0] = 32'h0004_0000; r.bx[1] = 32'h0005_0000;
      run_row('{req: r, chk: 1'b1, rsp: none});
      run_row('{req: make_req(fpec_pkg::FUNC_TEST, 0, 0), chk: 1'b1, rsp: vis});
      run_row('{req: make_req(fpec_pkg::FUNC_WRITE, 4'd3, 32'h7FFF_FFFF), chk: 1'b0,
                rsp: none});
      run_row('{req: make_req(fpec_pkg::FUNC_WRITE, 4'd15, 32'h8000_0000), chk: 1'b0,
                rsp: none});
      run_row('{req: make_req(fpec_pkg::FUNC_EXTRACT, 0, 0), chk: 1'b0, rsp: none});
      run_row('{req: rand_box(), chk: 1'b0, rsp: none});

      // random part: mostly box tests against random matrices
      for (n = 0; n < 250; n++) begin
         if (n > 220) calm = 1'b1;
         k = $urandom_range(0, 99);
         if (k < 4) begin
            cyc = $urandom_range(0, 3);
            for (i = 0; i < 16; i++) begin
               m[i] = rand_word(cyc == 0 ? 0 : (cyc == 1 ? 1 : 2));
               if (cyc == 3 && $urandom_range(0, 2) == 0) m[i] = 0;
               run_row('{req: make_req(fpec_pkg::FUNC_WRITE, 4'(i), m[i]), chk: 1'b0,
                         rsp: none});
            end
            run_row('{req: make_req(fpec_pkg::FUNC_EXTRACT, 0, 0), chk: 1'b0, rsp: none});
         end else if (k < 10) begin
            run_row('{req: make_req(fpec_pkg::FUNC_WRITE, 4'($urandom()),
                                    rand_word($urandom_range(0, 2))),
                      chk: 1'b0, rsp: none});
         end else if (k < 12) begin
            run_row('{req: make_req(fpec_pkg::FUNC_EXTRACT, 0, 0), chk: 1'b0, rsp: none});
         end else if (k < 13) begin
            r = rand_box();
            r.func = FUNC_UNUSED;
            run_row('{req: r, chk: 1'b0, rsp: none});
         end else begin
            run_row('{req: rand_box(), chk: 1'b0, rsp: none});
         end
      end
      req_bus.valid <= 1'b0;

      cyc = 0;
      while (expected_q.size() != 0 && cyc < 200_000) begin
         @(posedge clock);
         cyc++;
      end
      repeat (100) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("responses still outstanding: %0d", expected_q.size());
         err_count++;
      end
      $display("covered %0d box tests (%0d culled) and %0d extractions (%0d degenerate)",
               n_box, n_culled, n_ext, n_deg);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
